// File: design/bdda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_pkg: shared types and constants of the business day date adder
// Request and result payloads, the job record passed from the front end to
// the day stepper, error codes and calendar helper functions.
// ----------------------------------------------------------------------------
package bdda_pkg;

    // error codes of a result
    localparam logic [1:0] ERR_OK          = 2'd0;
    localparam logic [1:0] ERR_BAD_DATE    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW    = 2'd2;
    localparam logic [1:0] ERR_NO_BUSINESS = 2'd3;

    // calendar limits and mask values
    localparam logic [13:0] MAX_YEAR       = 14'd9999;
    localparam logic [6:0]  FULL_WEEK_MASK = 7'h7F;
    localparam logic [6:0]  MASK_RESET     = 7'd96;
    localparam logic [3:0]  LAST_MONTH     = 4'd12;
    localparam logic [2:0]  LAST_WEEKDAY   = 3'd6;
    localparam logic [6:0]  LAST_MOD100    = 7'd99;
    localparam logic [8:0]  LAST_MOD400    = 9'd399;

    // reciprocals: floor(x * RECIP_25 / 2^15) = x / 25 for x < 4096,
    // floor(x * RECIP_7 / 2^16) = x / 7 for x < 13107, above any weekday sum
    localparam logic [10:0] RECIP_25 = 11'd1311;
    localparam logic [13:0] RECIP_7  = 14'd9363;

    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [11:0] business_days;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  end_day;
        logic [3:0]  end_month;
        logic [13:0] end_year;
        logic [2:0]  end_weekday;
        logic [1:0]  error_code;
    } out_item_t;

    // classified request handed to the day stepper
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
        logic [11:0] left;
        logic [1:0]  mod4;
        logic [6:0]  mod100;
        logic [8:0]  mod400;
        logic [1:0]  err;
    } job_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // length of a month; zero for a month code outside 1..12
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                                  len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                               len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 of the weekday formula, with March as month one
    function automatic logic [4:0] month_offset(input logic [3:0] m);
        logic [4:0] off;
        case (m)
            4'd1:    off = 5'd28;
            4'd2:    off = 5'd31;
            4'd3:    off = 5'd2;
            4'd4:    off = 5'd5;
            4'd5:    off = 5'd7;
            4'd6:    off = 5'd10;
            4'd7:    off = 5'd12;
            4'd8:    off = 5'd15;
            4'd9:    off = 5'd18;
            4'd10:   off = 5'd20;
            4'd11:   off = 5'd23;
            4'd12:   off = 5'd25;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

// File: design/bdda_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_front: request intake and classification
// Captures a request, checks the start date, computes its weekday and the
// year residues used for leap years, and pushes a job into the queue.
// ----------------------------------------------------------------------------
module bdda_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bdda_pkg::in_item_t   in_item,
    input  logic [6:0]           weekend_mask,
    output logic                 push,
    output bdda_pkg::job_t       push_job,
    input  bdda_pkg::q_status_t  q_status
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIV  = 5'b00010,
        F_SUM  = 5'b00100,
        F_MOD  = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t        state_reg, state_next;
    bdda_pkg::in_item_t  item_reg;
    logic [13:0]         yy_reg;
    logic [7:0]          q_y100_reg;
    logic [7:0]          q_yy100_reg;
    logic [5:0]          q_yy400_reg;
    logic [14:0]         sum_reg;
    logic [12:0]         q7_reg;
    logic [1:0]          mod4_reg;
    logic [6:0]          mod100_reg;
    logic [8:0]          mod400_reg;
    logic [1:0]          err_reg;

    logic                early_month;
    logic [13:0]         yy;
    logic [22:0]         prod_y100;
    logic [22:0]         prod_yy100;
    logic [20:0]         prod_yy400;
    logic [13:0]         mod100_wide;
    logic [13:0]         mod400_wide;
    logic                leap;
    logic [4:0]          dim;
    logic                bad_date;
    logic [14:0]         sum;
    logic [28:0]         prod_7;
    logic [14:0]         rem_7;

    assign in_stall = (state_reg != F_IDLE);

    // divide-by-constant products on the captured year
    always_comb
    begin
        early_month = (item_reg.start_month < 4'd3);
        yy          = item_reg.start_year - 14'(early_month);
        prod_y100   = 23'(item_reg.start_year[13:2]) * 23'(bdda_pkg::RECIP_25);
        prod_yy100  = 23'(yy[13:2]) * 23'(bdda_pkg::RECIP_25);
        prod_yy400  = 21'(yy[13:4]) * 21'(bdda_pkg::RECIP_25);
    end

    // residues, date check and weekday sum
    always_comb
    begin
        mod100_wide = item_reg.start_year - 14'(q_y100_reg) * 14'd100;
        mod400_wide = item_reg.start_year - 14'(q_y100_reg[7:2]) * 14'd400;
        leap        = (item_reg.start_year[1:0] == 2'd0) &&
                      ((mod100_wide != 14'd0) || (mod400_wide == 14'd0));
        dim         = bdda_pkg::days_in_month(item_reg.start_month, leap);
        bad_date    = (item_reg.start_month < 4'd1) ||
                      (item_reg.start_month > bdda_pkg::LAST_MONTH) ||
                      (item_reg.start_year < 14'd1) ||
                      (item_reg.start_year > bdda_pkg::MAX_YEAR) ||
                      (item_reg.start_day < 5'd1) ||
                      (item_reg.start_day > dim);
        sum         = 15'(item_reg.start_day) + 15'(yy_reg) + 15'(yy_reg[13:2])
                      - 15'(q_yy100_reg) + 15'(q_yy400_reg)
                      + 15'(bdda_pkg::month_offset(item_reg.start_month));
    end

    // weekday as the remainder of the sum by seven
    always_comb
    begin
        prod_7 = 29'(sum_reg) * 29'(bdda_pkg::RECIP_7);
        rem_7  = sum_reg - 15'(q7_reg) * 15'd7;
    end

    // assemble the job
    always_comb
    begin
        push              = (state_reg == F_PUSH);
        push_job.day      = item_reg.start_day;
        push_job.month    = item_reg.start_month;
        push_job.year     = item_reg.start_year;
        push_job.weekday  = rem_7[2:0];
        push_job.left     = item_reg.business_days;
        push_job.mod4     = mod4_reg;
        push_job.mod100   = mod100_reg;
        push_job.mod400   = mod400_reg;
        push_job.err      = err_reg;
    end

    // sequence the classification steps
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (in_valid) state_next = F_DIV;
            F_DIV:   state_next = F_SUM;
            F_SUM:   state_next = F_MOD;
            F_MOD:   state_next = F_PUSH;
            F_PUSH:  if (!q_status.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // hold the request and intermediate values
    always_ff @(posedge clk)
    begin
        if ((state_reg == F_IDLE) && in_valid)
        begin
            item_reg <= in_item;
        end
        if (state_reg == F_DIV)
        begin
            yy_reg      <= yy;
            q_y100_reg  <= prod_y100[22:15];
            q_yy100_reg <= prod_yy100[22:15];
            q_yy400_reg <= prod_yy400[20:15];
        end
        if (state_reg == F_SUM)
        begin
            sum_reg    <= sum;
            mod4_reg   <= item_reg.start_year[1:0];
            mod100_reg <= mod100_wide[6:0];
            mod400_reg <= mod400_wide[8:0];
            if (bad_date)
            begin
                err_reg <= bdda_pkg::ERR_BAD_DATE;
            end
            else if (weekend_mask == bdda_pkg::FULL_WEEK_MASK)
            begin
                err_reg <= bdda_pkg::ERR_NO_BUSINESS;
            end
            else
            begin
                err_reg <= bdda_pkg::ERR_OK;
            end
        end
        if (state_reg == F_MOD)
        begin
            q7_reg <= prod_7[28:16];
        end
    end

endmodule

// File: design/bdda_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_queue: job queue between front end and day stepper
// A small first-in first-out buffer of classified jobs.
// ----------------------------------------------------------------------------
module bdda_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bdda_pkg::job_t       push_job,
    input  logic                 pop,
    output bdda_pkg::job_t       head,
    output bdda_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bdda_pkg::job_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: design/bdda_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_back: calendar day stepper
// Takes a job from the queue and steps one calendar day per cycle, counting
// business days and skipping weekends, then loads the result register.
// ----------------------------------------------------------------------------
module bdda_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [6:0]           weekend_mask,
    input  bdda_pkg::job_t       head,
    input  bdda_pkg::q_status_t  q_status,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bdda_pkg::out_item_t  out_item
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } back_state_t;

    back_state_t          state_reg, state_next;
    bdda_pkg::job_t       job_reg;
    logic                 out_valid_reg;
    bdda_pkg::out_item_t  out_item_reg;

    logic                 out_free;
    logic                 weekend;
    logic                 leap;
    logic [4:0]           dim;
    bdda_pkg::job_t       stepped;
    logic                 overflow;
    logic                 do_step;
    logic                 finish;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == B_IDLE) && !q_status.empty;

    // next calendar day of the current job
    always_comb
    begin
        leap     = (job_reg.mod4 == 2'd0) &&
                   ((job_reg.mod100 != 7'd0) || (job_reg.mod400 == 9'd0));
        dim      = bdda_pkg::days_in_month(job_reg.month, leap);
        stepped  = job_reg;
        overflow = 1'b0;
        if (job_reg.day >= dim)
        begin
            stepped.day = 5'd1;
            if (job_reg.month >= bdda_pkg::LAST_MONTH)
            begin
                overflow       = (job_reg.year >= bdda_pkg::MAX_YEAR);
                stepped.month  = 4'd1;
                stepped.year   = job_reg.year + 14'd1;
                stepped.mod4   = job_reg.mod4 + 2'd1;
                stepped.mod100 = (job_reg.mod100 == bdda_pkg::LAST_MOD100) ?
                                 7'd0 : job_reg.mod100 + 7'd1;
                stepped.mod400 = (job_reg.mod400 == bdda_pkg::LAST_MOD400) ?
                                 9'd0 : job_reg.mod400 + 9'd1;
            end
            else
            begin
                stepped.month = job_reg.month + 4'd1;
            end
        end
        else
        begin
            stepped.day = job_reg.day + 5'd1;
        end
        stepped.weekday = (job_reg.weekday == bdda_pkg::LAST_WEEKDAY) ?
                          3'd0 : job_reg.weekday + 3'd1;
        // count a business day as it passes
        if (!weekend)
        begin
            stepped.left = job_reg.left - 12'd1;
        end
    end

    // decide between stepping and finishing
    always_comb
    begin
        weekend = weekend_mask[job_reg.weekday];
        do_step = 1'b0;
        finish  = 1'b0;
        if (state_reg == B_RUN)
        begin
            if (job_reg.err != bdda_pkg::ERR_OK)
            begin
                finish = out_free;
            end
            else if (weekend || (job_reg.left != 12'd0))
            begin
                do_step = 1'b1;
            end
            else
            begin
                finish = out_free;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!q_status.empty) state_next = B_RUN;
            B_RUN:   if (finish) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // load the job, advance it, and capture the result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        else if (do_step)
        begin
            if (overflow)
            begin
                job_reg.err <= bdda_pkg::ERR_OVERFLOW;
            end
            else
            begin
                job_reg <= stepped;
            end
        end
        if (finish)
        begin
            out_item_reg.error_code <= job_reg.err;
            if (job_reg.err != bdda_pkg::ERR_OK)
            begin
                out_item_reg.end_day     <= '0;
                out_item_reg.end_month   <= '0;
                out_item_reg.end_year    <= '0;
                out_item_reg.end_weekday <= '0;
            end
            else
            begin
                out_item_reg.end_day     <= job_reg.day;
                out_item_reg.end_month   <= job_reg.month;
                out_item_reg.end_year    <= job_reg.year;
                out_item_reg.end_weekday <= job_reg.weekday;
            end
        end
    end

endmodule

// File: design/business_day_date_adder_unit.sv
`timescale 1ns / 1ps
// Path: front end states F_DIV, F_SUM, F_MOD, F_PUSH; the day stepper loads the job,
//   steps the leading weekend, counted days and trailing weekend, then finishes.
// Overlap: the front end takes a new request once it has pushed its job, while the
//   day stepper is still on an earlier one; the queue lets them overlap.
// Reset: weekend mask returns to Friday and Saturday, queue empties, no result.
// ----------------------------------------------------------------------------
// business_day_date_adder_unit: top level of the business day date adder
// Weekend mask register, front end, job queue and calendar day stepper.
// ----------------------------------------------------------------------------
module business_day_date_adder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bdda_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bdda_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [6:0]           cfg_wdata
);

    logic [6:0]           weekend_mask_reg;
    logic                 push;
    bdda_pkg::job_t       push_job;
    logic                 pop;
    bdda_pkg::job_t       head;
    bdda_pkg::q_status_t  q_status;

    // weekend mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weekend_mask_reg <= bdda_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            weekend_mask_reg <= cfg_wdata;
        end
    end

    bdda_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .weekend_mask (weekend_mask_reg),
        .push         (push),
        .push_job     (push_job),
        .q_status     (q_status)
    );

    bdda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    bdda_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .weekend_mask (weekend_mask_reg),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

endmodule

// File: design/bdda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_checker: port-level checks of the business day date adder
// Watches the result channel for held payloads and well-formed results.
// ----------------------------------------------------------------------------
module bdda_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input bdda_pkg::out_item_t  out_item
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

    // an error result carries no date
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.error_code != bdda_pkg::ERR_OK) |->
        (out_item.end_day == 5'd0) && (out_item.end_month == 4'd0) &&
        (out_item.end_year == 14'd0) && (out_item.end_weekday == 3'd0))
    else $error("error result has nonzero date fields");

    // a good result is a calendar date
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.error_code == bdda_pkg::ERR_OK) |->
        (out_item.end_day >= 5'd1) && (out_item.end_month >= 4'd1) &&
        (out_item.end_month <= bdda_pkg::LAST_MONTH) &&
        (out_item.end_weekday <= bdda_pkg::LAST_WEEKDAY))
    else $error("result date out of range");

    // a good result stays within the year range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.error_code == bdda_pkg::ERR_OK) |->
        (out_item.end_year >= 14'd1) && (out_item.end_year <= bdda_pkg::MAX_YEAR))
    else $error("result year out of range");

endmodule

bind business_day_date_adder_unit bdda_checker u_bdda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the business day date adder
// Drives dated requests through the valid/stall input channel, computes each
// return date with a day-by-day calendar walk kept in the bench, and compares
// every result field. Covers the reset weekend mask, invalid start dates, year
// overflow, other weekend masks including none and all, output back-pressure,
// sender pauses and random requests under random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 15_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    bdda_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall;
    bdda_pkg::out_item_t out_item;
    logic                cfg_we;
    logic [6:0]          cfg_wdata;

    // return dates predicted for accepted requests, oldest first
    bdda_pkg::out_item_t pending_returns[$];
    // bench copy of the weekend mask register
    logic [6:0] weekend_days = bdda_pkg::MASK_RESET;

    int fail_count         = 0;
    int returns_checked    = 0;
    int input_stall_cycles = 0;
    int masks_used         = 1;
    int cycle_count        = 0;
    int returns_by_code[4] = '{0, 0, 0, 0};
    int long_hold          = 0;
    bit no_gaps            = 1'b0;

    business_day_date_adder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Calendar walk
    // ------------------------------------------------------------------

    function automatic int month_length(int m, int y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:                      return leap ? 29 : 28;
            4, 6, 9, 11:            return 30;
            1, 3, 5, 7, 8, 10, 12:  return 31;
            default:                return 0;
        endcase
    endfunction

    // 0 Sunday; January and February count as months 11 and 12 of the prior year
    function automatic int weekday_of_date(int d, int m, int y);
        int yy;
        int mm;
        yy = (m < 3) ? y - 1 : y;
        mm = (m < 3) ? m + 10 : m - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    function automatic bdda_pkg::out_item_t predict_return_date(bdda_pkg::in_item_t req,
                                                                logic [6:0] mask);
        bdda_pkg::out_item_t ret;
        int                  day;
        int                  month;
        int                  year;
        int                  wday;
        int                  left;
        logic [1:0]          code;
        ret   = '0;
        day   = req.start_day;
        month = req.start_month;
        year  = req.start_year;
        left  = req.business_days;
        code  = bdda_pkg::ERR_OK;
        if (month < 1 || month > 12 || year < 1 || year > bdda_pkg::MAX_YEAR || day < 1
            || day > month_length(month, year))
            code = bdda_pkg::ERR_BAD_DATE;
        else if (mask == bdda_pkg::FULL_WEEK_MASK)
            code = bdda_pkg::ERR_NO_BUSINESS;
        else
        begin
            wday = weekday_of_date(day, month, year);
            // weekend days pass uncounted, business days use up the count;
            // stop on the first business day once nothing is left to count
            while (code == bdda_pkg::ERR_OK && (mask[wday] || left > 0))
            begin
                if (!mask[wday])
                    left--;
                if (day == 31 && month == 12 && year == bdda_pkg::MAX_YEAR)
                    code = bdda_pkg::ERR_OVERFLOW;
                else
                begin
                    if (day >= month_length(month, year))
                    begin
                        day = 1;
                        if (month == 12)
                        begin
                            month = 1;
                            year++;
                        end
                        else
                            month++;
                    end
                    else
                        day++;
                    wday = (wday + 1) % 7;
                end
            end
        end
        if (code == bdda_pkg::ERR_OK)
        begin
            ret.end_day     = 5'(day);
            ret.end_month   = 4'(month);
            ret.end_year    = 14'(year);
            ret.end_weekday = 3'(wday);
        end
        ret.error_code = code;
        return ret;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    function automatic bdda_pkg::in_item_t make_request(int d, int m, int y, int n);
        bdda_pkg::in_item_t r;
        r.start_day     = 5'(d);
        r.start_month   = 4'(m);
        r.start_year    = 14'(y);
        r.business_days = 12'(n);
        return r;
    endfunction

    function automatic bdda_pkg::in_item_t random_valid_date(int max_days);
        bdda_pkg::in_item_t r;
        r.start_year    = 14'($urandom_range(1, bdda_pkg::MAX_YEAR));
        r.start_month   = 4'($urandom_range(1, 12));
        r.start_day     = 5'($urandom_range(1, month_length(r.start_month, r.start_year)));
        r.business_days = 12'($urandom_range(0, max_days));
        return r;
    endfunction

    // mostly well-formed dates with short counts, some long counts,
    // some near the end of the calendar, and some raw noise
    function automatic bdda_pkg::in_item_t random_request();
        bdda_pkg::in_item_t r;
        int                 kind;
        kind = $urandom_range(0, 19);
        if (kind < 2)
            r = make_request($urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 16383), $urandom_range(0, 4095));
        else if (kind == 2)
            r = make_request($urandom_range(1, 31), 12, bdda_pkg::MAX_YEAR,
                             $urandom_range(0, 30));
        else if (kind == 3)
            r = random_valid_date(4095);
        else
            r = random_valid_date(40);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // offer one request after a random gap and hold it until accepted
    task automatic send_request(bdda_pkg::in_item_t req);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_returns.push_back(predict_return_date(req, weekend_days));
    endtask

    // drop valid and wait until every predicted return has arrived
    task automatic wait_for_returns();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_returns.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_weekend_mask(logic [6:0] mask);
        wait_for_returns();
        @(negedge clk);
        cfg_wdata <= mask;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        weekend_days = mask;
        masks_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset mask (Friday and Saturday): field extremes, zero count, leap years
    task automatic test_reset_mask();
        send_request(make_request(1, 1, 1, 0));
        send_request(make_request(31, 12, 9998, 0));
        send_request(make_request(15, 3, 2024, 0));
        send_request(make_request(28, 2, 2024, 3));
        send_request(make_request(29, 2, 2000, 10));
        send_request(make_request(1, 1, 2000, 4095));
    endtask

    task automatic test_invalid_dates();
        send_request(make_request(0, 6, 2010, 5));
        send_request(make_request(10, 0, 2010, 5));
        send_request(make_request(10, 13, 2010, 5));
        send_request(make_request(10, 15, 2010, 5));
        send_request(make_request(10, 6, 0, 5));
        send_request(make_request(10, 6, 10000, 5));
        send_request(make_request(31, 4, 2010, 5));
        send_request(make_request(29, 2, 1900, 5));
        send_request(make_request(31, 15, 16383, 4095));
    endtask

    // overflow during the count, the leading weekend and the trailing weekend
    task automatic test_year_overflow();
        send_request(make_request(24, 12, 9999, 10));
        send_request(make_request(31, 12, 9999, 1));
        send_request(make_request(31, 12, 9999, 0));
        send_request(make_request(30, 12, 9999, 1));
    endtask

    task automatic test_mask_settings();
        set_weekend_mask(7'h00);
        send_request(make_request(16, 3, 2024, 5));
        set_weekend_mask(bdda_pkg::FULL_WEEK_MASK);
        send_request(make_request(16, 3, 2024, 5));
        send_request(make_request(0, 3, 2024, 5));
        // only Saturday is a business day: the longest walk
        set_weekend_mask(7'h3F);
        send_request(make_request(1, 1, 2020, 4095));
        set_weekend_mask(7'h41);
        send_request(make_request(29, 12, 2023, 1));
        send_request(make_request(30, 12, 2023, 0));
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        wait_for_returns();
        long_hold = HOLD_CYCLES;
        repeat (12) send_request(random_valid_date(3));
    endtask

    // back-to-back burst, pause until drained, then another burst
    task automatic test_sender_pause();
        no_gaps = 1'b1;
        repeat (4) send_request(random_valid_date(20));
        wait_for_returns();
        repeat (4) send_request(random_valid_date(20));
        no_gaps = 1'b0;
    endtask

    task automatic test_random_mixes();
        logic [6:0] mask_plan[5];
        mask_plan[0] = bdda_pkg::MASK_RESET;
        mask_plan[1] = 7'h00;
        mask_plan[2] = 7'h41;
        mask_plan[3] = 7'h3F;
        mask_plan[4] = 7'($urandom_range(1, 126));
        for (int p = 0; p < 5; p++)
        begin
            set_weekend_mask(mask_plan[p]);
            no_gaps = (p == 2);
            repeat (11) send_request(random_request());
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // draw a stall per result; a requested long hold takes precedence
    initial
    begin : result_receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                n = long_hold;
                long_hold = 0;
            end
            else
                n = no_gaps ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall) && long_hold == 0);
        end
    end

    task automatic check_field(string name, logic [13:0] want, logic [13:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : return_checker
        bdda_pkg::out_item_t want;
        if (rst_n && in_valid && in_stall)
            input_stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_returns.size() == 0)
            begin
                $error("result with no request outstanding: %p", out_item);
                fail_count++;
            end
            else
            begin
                want = pending_returns.pop_front();
                check_field("end_day", 14'(want.end_day), 14'(out_item.end_day));
                check_field("end_month", 14'(want.end_month), 14'(out_item.end_month));
                check_field("end_year", want.end_year, out_item.end_year);
                check_field("end_weekday", 14'(want.end_weekday),
                            14'(out_item.end_weekday));
                check_field("error_code", 14'(want.error_code),
                            14'(out_item.error_code));
                returns_checked++;
                returns_by_code[want.error_code]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("timeout with %0d results outstanding", pending_returns.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : run_tests
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_mask();
        test_invalid_dates();
        test_year_overflow();
        test_mask_settings();
        test_backpressure();
        test_sender_pause();
        test_random_mixes();

        // drain, then leave room for any stray result
        wait_for_returns();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d return dates under %0d weekend masks: %0d ok, %0d bad start,",
                 returns_checked, masks_used, returns_by_code[bdda_pkg::ERR_OK],
                 returns_by_code[bdda_pkg::ERR_BAD_DATE]);
        $display("%0d past year 9999, %0d with no business day; input held off %0d cycles",
                 returns_by_code[bdda_pkg::ERR_OVERFLOW],
                 returns_by_code[bdda_pkg::ERR_NO_BUSINESS], input_stall_cycles);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
